// ----- rtl/core/bums_pkg.sv -----
`default_nettype none

package bums_pkg;

    localparam int DEPTH  = 64;
    localparam int KEY_W  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    // Holds 0..DEPTH.
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // Pointer math: base + 2*width stays below 4*DEPTH.
    localparam int PTR_W  = CNT_W + 2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] payload;
    } tuple_t;

    localparam int TUPLE_W = $bits(tuple_t);

    // One write port and one read port of a buffer RAM.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        tuple_t            wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_port_t;

    // Sorted beat handed to the output register.
    typedef struct packed {
        logic   load;
        tuple_t data;
        logic   last;
    } emit_t;

    // Merge step decision.
    typedef enum logic [2:0] {
        ACT_FETCH_P,
        ACT_FETCH_Q,
        ACT_TAKE_P,
        ACT_TAKE_Q,
        ACT_DONE
    } act_t;

endpackage

`default_nettype wire

// ----- rtl/core/bums_in_if.sv -----
`default_nettype none

interface bums_in_if;
    logic                       valid;
    logic                       ready;
    logic [bums_pkg::KEY_W-1:0] key;
    logic [bums_pkg::KEY_W-1:0] payload;
    logic                       final_item;

    modport source (output valid, output key, output payload, output final_item,
                    input ready);
    modport sink   (input valid, input key, input payload, input final_item,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bums_out_if.sv -----
`default_nettype none

interface bums_out_if;
    logic                       valid;
    logic                       ready;
    logic [bums_pkg::KEY_W-1:0] sorted_key;
    logic [bums_pkg::KEY_W-1:0] sorted_payload;
    logic                       run_end;

    modport source (output valid, output sorted_key, output sorted_payload,
                    output run_end, input ready);
    modport sink   (input valid, input sorted_key, input sorted_payload,
                    input run_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bums_ram.sv -----
`default_nettype none

module bums_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bums_pick.sv -----
`default_nettype none

module bums_pick (
    input  wire logic                       p_left,
    input  wire logic                       q_left,
    input  wire logic                       p_held,
    input  wire logic                       q_held,
    input  wire logic [bums_pkg::KEY_W-1:0] key_p,
    input  wire logic [bums_pkg::KEY_W-1:0] key_q,
    output      bums_pkg::act_t             act
);

    // Fill missing heads first, then take the smaller key; ties go right.
    always_comb
    begin
        if (p_left && !p_held)
        begin
            act = bums_pkg::ACT_FETCH_P;
        end
        else if (q_left && !q_held)
        begin
            act = bums_pkg::ACT_FETCH_Q;
        end
        else if (p_left && q_left)
        begin
            act = (key_p < key_q) ? bums_pkg::ACT_TAKE_P : bums_pkg::ACT_TAKE_Q;
        end
        else if (p_left)
        begin
            act = bums_pkg::ACT_TAKE_P;
        end
        else if (q_left)
        begin
            act = bums_pkg::ACT_TAKE_Q;
        end
        else
        begin
            act = bums_pkg::ACT_DONE;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bums_seq.sv -----
`default_nettype none

module bums_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    bums_in_if.sink                  tuple_in,
    input  wire logic                out_free,
    input  wire bums_pkg::tuple_t    rdata_a,
    input  wire bums_pkg::tuple_t    rdata_b,
    output      bums_pkg::ram_port_t ram_a,
    output      bums_pkg::ram_port_t ram_b,
    output      bums_pkg::emit_t     emit
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SEG,
        S_RUN,
        S_WAIT_P,
        S_WAIT_Q,
        S_EM_RD,
        S_EM_WAIT
    } state_t;

    localparam int PW = bums_pkg::PTR_W;
    localparam int CW = bums_pkg::CNT_W;
    localparam int AW = bums_pkg::ADDR_W;

    state_t           state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [PW-1:0]    width_reg, width_next;
    logic [PW-1:0]    base_reg, base_next;
    logic [PW-1:0]    mid_reg, mid_next;
    logic [PW-1:0]    hi_reg, hi_next;
    logic [PW-1:0]    p_reg, p_next;
    logic [PW-1:0]    q_reg, q_next;
    logic [PW-1:0]    wr_reg, wr_next;
    bums_pkg::tuple_t head_p_reg, head_p_next;
    bums_pkg::tuple_t head_q_reg, head_q_next;
    logic             hp_v_reg, hp_v_next;
    logic             hq_v_reg, hq_v_next;
    logic             src_b_reg, src_b_next;

    logic             accept;
    logic             room;
    logic [CW-1:0]    n_new;
    logic [PW-1:0]    n_ext;
    logic [PW-1:0]    mid_sum, mid_cl, hi_sum, hi_cl;
    logic [PW-1:0]    two_w, base_step;
    bums_pkg::act_t   act;
    logic             run_take;
    bums_pkg::tuple_t take_tuple;
    bums_pkg::tuple_t src_data;
    logic [AW-1:0]    rd_addr;
    logic             load_we;

    bums_pick u_pick (
        .p_left (p_reg < mid_reg),
        .q_left (q_reg < hi_reg),
        .p_held (hp_v_reg),
        .q_held (hq_v_reg),
        .key_p  (head_p_reg.key),
        .key_q  (head_q_reg.key),
        .act    (act)
    );

    assign tuple_in.ready = (state_reg == S_LOAD);
    assign accept         = tuple_in.valid && (state_reg == S_LOAD);
    assign room           = (cnt_reg < CW'(bums_pkg::DEPTH));
    assign n_new          = cnt_reg + CW'(room);
    assign n_ext          = PW'(n_reg);

    assign mid_sum   = base_reg + width_reg;
    assign mid_cl    = (mid_sum > n_ext) ? n_ext : mid_sum;
    assign hi_sum    = mid_cl + width_reg;
    assign hi_cl     = (hi_sum > n_ext) ? n_ext : hi_sum;
    assign two_w     = width_reg << 1;
    assign base_step = base_reg + two_w;

    assign run_take   = (state_reg == S_RUN)
                        && ((act == bums_pkg::ACT_TAKE_P) || (act == bums_pkg::ACT_TAKE_Q));
    assign take_tuple = (act == bums_pkg::ACT_TAKE_P) ? head_p_reg : head_q_reg;
    assign src_data   = src_b_reg ? rdata_b : rdata_a;
    assign load_we    = accept && room;
    assign rd_addr    = ((state_reg == S_RUN) && (act == bums_pkg::ACT_FETCH_Q))
                        ? q_reg[AW-1:0] : p_reg[AW-1:0];

    // Loads go to the primary buffer; a merge writes the buffer it is not reading.
    always_comb
    begin
        ram_a.we    = load_we || (run_take && src_b_reg);
        ram_a.waddr = (state_reg == S_LOAD) ? cnt_reg[AW-1:0] : wr_reg[AW-1:0];
        ram_a.wdata = (state_reg == S_LOAD)
                      ? bums_pkg::tuple_t'({tuple_in.key, tuple_in.payload}) : take_tuple;
        ram_a.raddr = rd_addr;
        ram_b.we    = run_take && !src_b_reg;
        ram_b.waddr = wr_reg[AW-1:0];
        ram_b.wdata = take_tuple;
        ram_b.raddr = rd_addr;
    end

    always_comb
    begin
        emit.load = (state_reg == S_EM_WAIT);
        emit.data = src_data;
        emit.last = ((p_reg + PW'(1)) == n_ext);
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        width_next  = width_reg;
        base_next   = base_reg;
        mid_next    = mid_reg;
        hi_next     = hi_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        wr_next     = wr_reg;
        head_p_next = head_p_reg;
        head_q_next = head_q_reg;
        hp_v_next   = hp_v_reg;
        hq_v_next   = hq_v_reg;
        src_b_next  = src_b_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cnt_next = n_new;
                    if (tuple_in.final_item)
                    begin
                        n_next     = n_new;
                        cnt_next   = '0;
                        src_b_next = 1'b0;
                        width_next = PW'(1);
                        base_next  = '0;
                        p_next     = '0;
                        state_next = (n_new <= CW'(1)) ? S_EM_RD : S_SEG;
                    end
                end
            end
            S_SEG:
            begin
                mid_next   = mid_cl;
                hi_next    = hi_cl;
                p_next     = base_reg;
                q_next     = mid_cl;
                wr_next    = base_reg;
                hp_v_next  = 1'b0;
                hq_v_next  = 1'b0;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                case (act)
                    bums_pkg::ACT_FETCH_P: state_next = S_WAIT_P;
                    bums_pkg::ACT_FETCH_Q: state_next = S_WAIT_Q;
                    bums_pkg::ACT_TAKE_P:
                    begin
                        p_next    = p_reg + PW'(1);
                        wr_next   = wr_reg + PW'(1);
                        hp_v_next = 1'b0;
                    end
                    bums_pkg::ACT_TAKE_Q:
                    begin
                        q_next    = q_reg + PW'(1);
                        wr_next   = wr_reg + PW'(1);
                        hq_v_next = 1'b0;
                    end
                    default:
                    begin
                        if (base_step >= n_ext)
                        begin
                            width_next = two_w;
                            src_b_next = !src_b_reg;
                            base_next  = '0;
                            p_next     = '0;
                            state_next = (two_w >= n_ext) ? S_EM_RD : S_SEG;
                        end
                        else
                        begin
                            base_next  = base_step;
                            state_next = S_SEG;
                        end
                    end
                endcase
            end
            S_WAIT_P:
            begin
                head_p_next = src_data;
                hp_v_next   = 1'b1;
                state_next  = S_RUN;
            end
            S_WAIT_Q:
            begin
                head_q_next = src_data;
                hq_v_next   = 1'b1;
                state_next  = S_RUN;
            end
            S_EM_RD:
            begin
                if (out_free)
                begin
                    state_next = S_EM_WAIT;
                end
            end
            S_EM_WAIT:
            begin
                p_next     = p_reg + PW'(1);
                state_next = emit.last ? S_LOAD : S_EM_RD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            n_reg     <= '0;
            width_reg <= '0;
            base_reg  <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            p_reg     <= '0;
            q_reg     <= '0;
            wr_reg    <= '0;
            hp_v_reg  <= 1'b0;
            hq_v_reg  <= 1'b0;
            src_b_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            n_reg      <= n_next;
            width_reg  <= width_next;
            base_reg   <= base_next;
            mid_reg    <= mid_next;
            hi_reg     <= hi_next;
            p_reg      <= p_next;
            q_reg      <= q_next;
            wr_reg     <= wr_next;
            head_p_reg <= head_p_next;
            head_q_reg <= head_q_next;
            hp_v_reg   <= hp_v_next;
            hq_v_reg   <= hq_v_next;
            src_b_reg  <= src_b_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bottom_up_merge_sorter.sv -----
// Channel     | Dir | Beat fields                              | Accepted when
// ------------+-----+------------------------------------------+---------------
// tuple_in    | in  | key, payload, final_item                 | valid && ready
// sorted_out  | out | sorted_key, sorted_payload, run_end      | valid && ready
//
// Loading takes one cycle per beat; ready is high only in the load phase.
// Each merge pass reads, captures and writes one tuple at a time, and sets up and closes each
// run pair; there are ceil(log2(n)) passes, paced by the single read port of the source RAM.
// Emission reads each tuple from the RAM, then loads it into the output register once that is free or draining.
// Reset clears control only; the buffer RAMs need no clearing pass.
// The output register holds a stalled beat; the next data set may load behind the last.
`default_nettype none

module bottom_up_merge_sorter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bums_in_if.sink    tuple_in,
    bums_out_if.source sorted_out
);

    bums_pkg::ram_port_t ram_a;
    bums_pkg::ram_port_t ram_b;
    bums_pkg::tuple_t    rdata_a;
    bums_pkg::tuple_t    rdata_b;
    bums_pkg::emit_t     emit;
    logic                out_free;

    // Output register.
    logic                out_valid_reg;
    bums_pkg::tuple_t    out_data_reg;
    logic                out_last_reg;

    // Primary buffer: loads land here, and even passes read it.
    bums_ram #(
        .WIDTH (bums_pkg::TUPLE_W),
        .DEPTH (bums_pkg::DEPTH)
    ) u_primary (
        .clk   (clk),
        .we    (ram_a.we),
        .waddr (ram_a.waddr),
        .wdata (ram_a.wdata),
        .raddr (ram_a.raddr),
        .rdata (rdata_a)
    );

    // Scratch buffer: ping-pong partner of the primary buffer.
    bums_ram #(
        .WIDTH (bums_pkg::TUPLE_W),
        .DEPTH (bums_pkg::DEPTH)
    ) u_scratch (
        .clk   (clk),
        .we    (ram_b.we),
        .waddr (ram_b.waddr),
        .wdata (ram_b.wdata),
        .raddr (ram_b.raddr),
        .rdata (rdata_b)
    );

    // Load, merge passes and emit sequencing.
    bums_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .tuple_in (tuple_in),
        .out_free (out_free),
        .rdata_a  (rdata_a),
        .rdata_b  (rdata_b),
        .ram_a    (ram_a),
        .ram_b    (ram_b),
        .emit     (emit)
    );

    // Free if empty or draining this cycle; the sequencer reads only then.
    assign out_free = !out_valid_reg || sorted_out.ready;

    // Hold the beat until taken; load the next one from the RAM read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= emit.data;
            out_last_reg  <= emit.last;
        end
        else if (sorted_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sorted_out.valid          = out_valid_reg;
    assign sorted_out.sorted_key     = out_data_reg.key;
    assign sorted_out.sorted_payload = out_data_reg.payload;
    assign sorted_out.run_end        = out_last_reg;

    // A new beat never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit.load |-> !out_valid_reg)
        else $error("output beat overwritten");

    // Input is never taken while a sorted beat is being produced.
    a_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
        tuple_in.ready |-> !emit.load)
        else $error("load and emit overlap");

    // A merge writes only the destination buffer.
    a_one_dst: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_a.we && ram_b.we))
        else $error("both buffers written in one cycle");

    // The last beat of a burst returns the block to loading.
    a_end_load: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.load && emit.last) |=> tuple_in.ready)
        else $error("no return to load after last beat");

endmodule

`default_nettype wire

// ----- test/tuple_sort_check_pkg.sv -----
package tuple_sort_check_pkg;

    import bums_pkg::*;

    typedef struct packed {
        tuple_t data;
        logic   last;
    } sorted_beat_t;

    class tuple_sort_scoreboard;
        tuple_t       loaded_q[$];
        sorted_beat_t sorted_q[$];
        int           mismatches;
        int           beats_checked;

        function new();
            mismatches    = 0;
            beats_checked = 0;
        endfunction

        function int pending();
            return sorted_q.size();
        endfunction

        // Bottom-up merge sort of the loaded tuples; equal keys take the right run first.
        function void merge_sort_loaded();
            tuple_t src[];
            tuple_t dst[];
            int     n;
            int     width;
            int     lo;
            int     mid;
            int     hi;
            int     p;
            int     q;
            int     w;
            n   = loaded_q.size();
            src = new[n];
            dst = new[n];
            foreach (loaded_q[i])
            begin
                src[i] = loaded_q[i];
            end
            for (width = 1; width < n; width = width * 2)
            begin
                for (lo = 0; lo < n; lo += 2 * width)
                begin
                    mid = (lo + width > n) ? n : lo + width;
                    hi  = (mid + width > n) ? n : mid + width;
                    p   = lo;
                    q   = mid;
                    w   = lo;
                    while (p < mid && q < hi)
                    begin
                        if (src[p].key < src[q].key)
                        begin
                            dst[w] = src[p];
                            p++;
                        end
                        else
                        begin
                            dst[w] = src[q];
                            q++;
                        end
                        w++;
                    end
                    while (p < mid)
                    begin
                        dst[w] = src[p];
                        p++;
                        w++;
                    end
                    while (q < hi)
                    begin
                        dst[w] = src[q];
                        q++;
                        w++;
                    end
                end
                src = dst;
            end
            for (int i = 0; i < n; i++)
            begin
                sorted_q.push_back('{data: src[i], last: (i == n - 1)});
            end
        endfunction

        // Hold the tuple unless the buffer is full; close the set on the final beat.
        function void note_tuple(input logic [KEY_W-1:0] key,
                                 input logic [KEY_W-1:0] payload,
                                 input logic             final_item);
            if (loaded_q.size() < DEPTH)
            begin
                loaded_q.push_back('{key: key, payload: payload});
            end
            if (final_item)
            begin
                merge_sort_loaded();
                loaded_q.delete();
            end
        endfunction

        task report_mismatch(input string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_beat(input logic [KEY_W-1:0] sorted_key,
                        input logic [KEY_W-1:0] sorted_payload,
                        input logic             run_end);
            sorted_beat_t exp;
            beats_checked++;
            if (sorted_q.size() == 0)
            begin
                report_mismatch($sformatf("beat key %h payload %h with nothing pending",
                                          sorted_key, sorted_payload));
                return;
            end
            exp = sorted_q.pop_front();
            if (sorted_key !== exp.data.key)
            begin
                report_mismatch($sformatf("sorted_key %h, want %h",
                                          sorted_key, exp.data.key));
            end
            if (sorted_payload !== exp.data.payload)
            begin
                report_mismatch($sformatf("sorted_payload %h, want %h (key %h)",
                                          sorted_payload, exp.data.payload, exp.data.key));
            end
            if (run_end !== exp.last)
            begin
                report_mismatch($sformatf("run_end %b, want %b (key %h)",
                                          run_end, exp.last, exp.data.key));
            end
        endtask
    endclass

endpackage

// ----- test/testbench.sv -----
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import bums_pkg::*;
    import tuple_sort_check_pkg::*;

    // Stop offering random sets once this many random tuples have gone in.
    localparam int RANDOM_ITEMS    = 480;
    // Per-cycle chance, in percent, that either side idles.
    localparam int IDLE_PERCENT    = 28;
    // Long back-pressure window on the sorted side, in cycles.
    localparam int HOLD_OFF_CYCLES = 600;
    // Start the hold-off once this many sorted beats have been checked.
    localparam int HOLD_OFF_AFTER  = 120;
    // Quiet cycles after the last sorted beat before the verdict.
    localparam int SETTLE_CYCLES   = 50;
    // Give up after 2 ms, far past the slowest correct run.
    localparam int RUN_LIMIT_NS    = 2_000_000;

    logic clk;
    logic rst_n;
    // High while both sides run with no idling at all.
    bit   steady;
    int   random_items_sent;

    tuple_sort_scoreboard sb = new();

    bums_in_if  tuple_in_bus();
    bums_out_if sorted_out_bus();

    bottom_up_merge_sorter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tuple_in   (tuple_in_bus),
        .sorted_out (sorted_out_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: a hung handshake or a lost beat ends up here.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one tuple. Idle at random first, then hold valid until the block
    // takes the beat, and note the accepted tuple for the sorted prediction.
    // Called and returns at a falling edge.
    task send_tuple(input logic [KEY_W-1:0] key,
                    input logic [KEY_W-1:0] payload,
                    input logic             final_item);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            tuple_in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        tuple_in_bus.valid      <= 1'b1;
        tuple_in_bus.key        <= key;
        tuple_in_bus.payload    <= payload;
        tuple_in_bus.final_item <= final_item;
        // Ready drops for the whole sort and emit; keep offering until it returns.
        do
            @(posedge clk);
        while (!tuple_in_bus.ready);
        sb.note_tuple(key, payload, final_item);
        @(negedge clk);
    endtask

    // Send a data set of n random tuples, the last one marked final.
    // Key flavors: full range, a tiny range full of duplicates, or
    // clustered at the top of the range.
    task send_set(input int n, input int key_flavor);
        logic [KEY_W-1:0] key;
        for (int i = 0; i < n; i++)
        begin
            case (key_flavor)
                0:       key = $urandom_range(15);
                1:       key = 32'hFFFF_FFF0 | $urandom_range(15);
                default: key = $urandom;
            endcase
            send_tuple(key, $urandom, i == n - 1);
            random_items_sent++;
        end
    endtask

    // Sorted side: drop ready at random, hold off once for a long stretch so
    // the block fills and stalls its input, and never idle while steady.
    initial
    begin
        bit held_off;
        held_off             = 1'b0;
        sorted_out_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && sb.beats_checked >= HOLD_OFF_AFTER)
            begin
                held_off = 1'b1;
                sorted_out_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            sorted_out_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Check every sorted beat taken at a rising edge.
    always @(posedge clk)
    begin
        if (rst_n && sorted_out_bus.valid && sorted_out_bus.ready)
        begin
            sb.check_beat(sorted_out_bus.sorted_key, sorted_out_bus.sorted_payload,
                          sorted_out_bus.run_end);
        end
    end

    initial
    begin
        int set_idx;
        int set_len;
        int pick;

        rst_n                   = 1'b0;
        steady                  = 1'b0;
        random_items_sent       = 0;
        tuple_in_bus.valid      = 1'b0;
        tuple_in_bus.key        = '0;
        tuple_in_bus.payload    = '0;
        tuple_in_bus.final_item = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Single-tuple sets pass straight through, at both key extremes.
        send_tuple(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_tuple(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        // Two equal keys: the right one comes out first.
        send_tuple(32'h0000_0005, 32'h0000_000A, 1'b0);
        send_tuple(32'h0000_0005, 32'h0000_000B, 1'b1);
        // Fully descending set with alternating bit patterns.
        send_tuple(32'hFFFF_FFFF, 32'h5555_5555, 1'b0);
        send_tuple(32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0);
        send_tuple(32'h5555_5555, 32'hFFFF_FFFF, 1'b0);
        send_tuple(32'h0000_0000, 32'h0000_0000, 1'b1);
        // Odd-sized set with repeated keys; the last run has no partner.
        send_tuple(32'h0000_0007, 32'h0000_0001, 1'b0);
        send_tuple(32'h0000_0003, 32'h0000_0002, 1'b0);
        send_tuple(32'h0000_0007, 32'h0000_0003, 1'b0);
        send_tuple(32'h0000_0003, 32'h0000_0004, 1'b0);
        send_tuple(32'h0000_0007, 32'h0000_0005, 1'b1);
        // Already ascending set.
        send_tuple(32'h0000_0001, 32'h8000_0000, 1'b0);
        send_tuple(32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        send_tuple(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);

        // Random sets, mostly short. Force one overflowing set, whose
        // discarded final tuple still closes it, and one exactly full set.
        set_idx = 0;
        while (random_items_sent < RANDOM_ITEMS)
        begin
            steady = (set_idx >= 6 && set_idx < 10);
            if (set_idx == 2)
            begin
                set_len = DEPTH + 6;
            end
            else if (set_idx == 5)
            begin
                set_len = DEPTH;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    set_len = $urandom_range(16, 1);
                else if (pick < 85)
                    set_len = $urandom_range(DEPTH - 1, 17);
                else if (pick < 93)
                    set_len = DEPTH;
                else
                    set_len = $urandom_range(DEPTH + 8, DEPTH + 1);
            end
            send_set(set_len, $urandom_range(3));
            set_idx++;
        end
        steady = 1'b0;
        tuple_in_bus.valid <= 1'b0;

        // Every set closed with a final tuple, so wait for the last sorted
        // beat, then watch a little longer for stray beats.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- bottom_up_merge_sorter.f -----
rtl/core/bums_pkg.sv
rtl/core/bums_in_if.sv
rtl/core/bums_out_if.sv
rtl/core/bums_ram.sv
rtl/core/bums_pick.sv
rtl/core/bums_seq.sv
rtl/core/bottom_up_merge_sorter.sv
test/tuple_sort_check_pkg.sv
test/testbench.sv
